// ----- sv/tkrs_pkg.sv -----
// Shared types, constants and the ordering function of the two-key record sorter.
package tkrs_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = IDX_W + 1;
   localparam int NUM_W = 9;
   localparam logic [NUM_W-1:0] NUM_MAX = '1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TAKE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [31:0] first_key;
      logic [31:0] second_key;
   } req_entry_type;

   typedef struct packed {
      logic [31:0]      first_key;
      logic [31:0]      second_key;
      logic [NUM_W-1:0] number;
   } record_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   // True when record a goes strictly before record b by key alone.
   function automatic logic goes_before(input record_type a, input record_type b);
      logic pri_gt;
      logic pri_eq;
      logic sec_lt;
      pri_gt = $signed(a.first_key) > $signed(b.first_key);
      pri_eq = a.first_key == b.first_key;
      sec_lt = $signed(a.second_key) < $signed(b.second_key);
      return pri_gt || (pri_eq && sec_lt);
   endfunction

endpackage

// ----- sv/tkrs_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface tkrs_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] first_key;
   logic [31:0] second_key;
   modport source (output valid, output command, output first_key, output second_key,
                   input ready);
   modport sink (input valid, input command, input first_key, input second_key,
                 output ready);
endinterface

interface tkrs_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tkrs_pkg::NUM_W-1:0] record_number;
   logic                      final_one;
   logic                      was_empty;
   logic                      overflowed;
   modport source (output valid, output record_number, output final_one,
                   output was_empty, output overflowed, input ready);
   modport sink (input valid, input record_number, input final_one,
                 input was_empty, input overflowed, output ready);
endinterface

// ----- sv/tkrs_front.sv -----
// Front end: accepts request transfers and queues them with their command.
module tkrs_front (
   input  logic                     clock,
   input  logic                     reset,
   tkrs_req_if.sink                 req_chan,
   output tkrs_pkg::queue_head_type head,
   input  logic                     pop
);

   tkrs_pkg::req_entry_type q_mem [tkrs_pkg::QUEUE_DEPTH];
   logic [tkrs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tkrs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tkrs_pkg::QPTR_W:0]   count_ff, count_in;
   logic push;
   logic do_pop;

   assign req_chan.ready = count_ff != (tkrs_pkg::QPTR_W+1)'(tkrs_pkg::QUEUE_DEPTH);
   assign push = req_chan.valid && req_chan.ready;
   assign do_pop = pop && head.valid;

   assign head.valid = count_ff != '0;
   assign head.entry = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (tkrs_pkg::QPTR_W+1)'(push) - (tkrs_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         // Only the low bit of the command is meaningful.
         q_mem[wr_ptr_ff] <= '{command: req_chan.command,
                               first_key: req_chan.first_key,
                               second_key: req_chan.second_key};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/tkrs_back.sv -----
// Back end: record memory, best-record search, compaction and the response register.
module tkrs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  tkrs_pkg::queue_head_type head,
   output logic                     pop,
   tkrs_rsp_if.source               rsp_chan
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SCAN_RD  = 7'b0000010,
      ST_SCAN_CMP = 7'b0000100,
      ST_SHIFT_RD = 7'b0001000,
      ST_SHIFT_WR = 7'b0010000,
      ST_FIN      = 7'b0100000,
      ST_SPARE    = 7'b1000000
   } state_type;

   localparam logic [tkrs_pkg::CNT_W-1:0] CAP_CNT = tkrs_pkg::CNT_W'(tkrs_pkg::CAPACITY);

   // Records are kept in arrival order, so the first best entry is the earliest.
   tkrs_pkg::record_type mem [tkrs_pkg::CAPACITY];

   state_type state_ff, state_in;
   logic [tkrs_pkg::CNT_W-1:0] fill_ff, fill_in;
   logic [tkrs_pkg::NUM_W-1:0] arrival_ff, arrival_in;
   logic ovf_ff, ovf_in;
   logic [tkrs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [tkrs_pkg::IDX_W-1:0] best_idx_ff, best_idx_in;
   tkrs_pkg::record_type best_ff, best_in;
   logic empty_ff, empty_in;
   tkrs_pkg::record_type rd_data_ff;

   logic out_vld_ff, out_vld_in;
   logic [tkrs_pkg::NUM_W-1:0] out_num_ff, out_num_in;
   logic out_final_ff, out_final_in;
   logic out_empty_ff, out_empty_in;
   logic out_ovf_ff, out_ovf_in;

   logic mem_we;
   logic [tkrs_pkg::IDX_W-1:0] mem_wa;
   tkrs_pkg::record_type mem_wd;
   logic mem_re;
   logic [tkrs_pkg::IDX_W-1:0] mem_ra;
   logic at_last;
   logic out_free;

   assign at_last = {1'b0, idx_ff} == fill_ff - 1'b1;
   assign out_free = !out_vld_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      arrival_in = arrival_ff;
      ovf_in = ovf_ff;
      idx_in = idx_ff;
      best_idx_in = best_idx_ff;
      best_in = best_ff;
      empty_in = empty_ff;
      pop = 1'b0;
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = rd_data_ff;
      mem_re = 1'b0;
      mem_ra = idx_ff;
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      out_num_in = out_num_ff;
      out_final_in = out_final_ff;
      out_empty_in = out_empty_ff;
      out_ovf_in = out_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.entry.command == tkrs_pkg::CMD_INSERT) begin
                  if (fill_ff == CAP_CNT) begin
                     ovf_in = 1'b1;
                  end else begin
                     arrival_in = (arrival_ff == tkrs_pkg::NUM_MAX) ? arrival_ff
                                                                   : arrival_ff + 1'b1;
                     mem_we = 1'b1;
                     mem_wa = fill_ff[tkrs_pkg::IDX_W-1:0];
                     mem_wd = '{first_key: head.entry.first_key,
                                second_key: head.entry.second_key,
                                number: arrival_in};
                     fill_in = fill_ff + 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  empty_in = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  empty_in = 1'b0;
                  idx_in = '0;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            mem_re = 1'b1;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (idx_ff == '0 || tkrs_pkg::goes_before(rd_data_ff, best_ff)) begin
               best_in = rd_data_ff;
               best_idx_in = idx_ff;
            end
            if (at_last) begin
               idx_in = best_in == rd_data_ff && best_idx_in == idx_ff ? idx_ff : best_idx_in;
               state_in = ST_SHIFT_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (at_last) begin
               fill_in = fill_ff - 1'b1;
               if (fill_ff == tkrs_pkg::CNT_W'(1)) begin
                  arrival_in = '0;
               end
               state_in = ST_FIN;
            end else begin
               mem_re = 1'b1;
               mem_ra = idx_ff + 1'b1;
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_FIN: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_num_in = empty_ff ? '0 : best_ff.number;
               out_final_in = !empty_ff && fill_ff == '0;
               out_empty_in = empty_ff;
               out_ovf_in = ovf_ff;
               state_in = ST_IDLE;
            end
         end
         ST_SPARE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      best_idx_ff <= best_idx_in;
      idx_ff <= idx_in;
      empty_ff <= empty_in;
      out_num_ff <= out_num_in;
      out_final_ff <= out_final_in;
      out_empty_ff <= out_empty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         arrival_ff <= '0;
         ovf_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         out_ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         arrival_ff <= arrival_in;
         ovf_ff <= ovf_in;
         out_vld_ff <= out_vld_in;
         out_ovf_ff <= out_ovf_in;
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.record_number = out_num_ff;
   assign rsp_chan.final_one = out_final_ff;
   assign rsp_chan.was_empty = out_empty_ff;
   assign rsp_chan.overflowed = out_ovf_ff;

endmodule

// ----- sv/two_key_record_sorter.sv -----
// Top level of the two-key record sorter: front queue, back engine and checks.
//
//   channel   | direction | payload
//   req_chan  | in        | command, first_key, second_key
//   rsp_chan  | out       | record_number, final_one, was_empty, overflowed
//
// An insert is stored directly from the idle state. A take on stored records runs
// a search over the record memory, then compaction of the entries after the best
// record, both limited by its single read port. A take on an empty store skips
// the search and compaction.
// Reset is synchronous and clears the fill count, arrival counter and overflow
// flag; the record memory needs no clearing, as only filled entries are read.
// The request queue holds four transfers, so until it is full the front keeps
// accepting while the back engine is busy or the response register waits for its transfer.
module two_key_record_sorter (
   input logic        clock,
   input logic        reset,
   tkrs_req_if.sink   req_chan,
   tkrs_rsp_if.source rsp_chan
);

   tkrs_pkg::queue_head_type head;
   logic pop;

   tkrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   tkrs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_empty_not_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.was_empty && rsp_chan.final_one))
      else $error("empty take also reported as final");

   a_empty_number: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.was_empty |-> rsp_chan.record_number == '0)
      else $error("empty take carries a record number");

   a_found_number: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.was_empty |-> rsp_chan.record_number != '0)
      else $error("taken record has number zero");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.overflowed |=> rsp_chan.overflowed)
      else $error("overflow flag cleared");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the two-key record sorter with a sorted-store predictor.
module tb;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 4 * tkrs_pkg::CAPACITY + 100;

   typedef struct {
      logic [tkrs_pkg::NUM_W-1:0] record_number;
      logic                       final_one;
      logic                       was_empty;
      logic                       overflowed;
   } take_result_type;

   logic clock;
   logic reset;

   tkrs_req_if req_bus ();
   tkrs_rsp_if rsp_bus ();

   two_key_record_sorter uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   tkrs_pkg::req_entry_type pending_requests[$];
   take_result_type         expected_takes[$];

   // Predictor state: records kept best first.
   logic signed [31:0]         sorted_first[$];
   logic signed [31:0]         sorted_second[$];
   logic [tkrs_pkg::NUM_W-1:0] sorted_number[$];
   logic [tkrs_pkg::NUM_W-1:0] arrivals;
   logic                       overflow_seen;

   int error_count;
   int accepted_count;
   int total_requests;
   int idle_cycles;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function automatic void queue_request(input logic cmd, input logic [31:0] p,
                                         input logic [31:0] s);
      tkrs_pkg::req_entry_type e;
      e.command = cmd;
      e.first_key = p;
      e.second_key = s;
      pending_requests.insert(pending_requests.size(), e);
   endfunction

   function automatic logic [31:0] pick_key();
      case ($urandom_range(5))
         0: return $urandom_range(4) - 2;
         1: return 32'h8000_0000 + $urandom_range(1);
         2: return 32'h7fff_fffe + $urandom_range(1);
         3: return $urandom_range(2);
         default: return $urandom;
      endcase
   endfunction

   // Applies one accepted request to the predicted store.
   function automatic void predict_request(input tkrs_pkg::req_entry_type e);
      take_result_type r;
      int pos;
      logic signed [31:0] p;
      logic signed [31:0] s;
      p = e.first_key;
      s = e.second_key;
      if (e.command == tkrs_pkg::CMD_INSERT) begin
         if (sorted_number.size() >= tkrs_pkg::CAPACITY) begin
            overflow_seen = 1'b1;
            return;
         end
         if (arrivals != tkrs_pkg::NUM_MAX) arrivals++;
         pos = 0;
         // Equal keys and equal numbers keep arrival order, so a new record goes after them.
         while (pos < sorted_number.size() &&
                !(p > sorted_first[pos] ||
                  (p == sorted_first[pos] && s < sorted_second[pos]) ||
                  (p == sorted_first[pos] && s == sorted_second[pos] &&
                   arrivals < sorted_number[pos])))
            pos++;
         sorted_first.insert(pos, p);
         sorted_second.insert(pos, s);
         sorted_number.insert(pos, arrivals);
         return;
      end
      r.overflowed = overflow_seen;
      if (sorted_number.size() == 0) begin
         r.record_number = '0;
         r.final_one = 1'b0;
         r.was_empty = 1'b1;
      end else begin
         r.record_number = sorted_number.pop_front();
         void'(sorted_first.pop_front());
         void'(sorted_second.pop_front());
         r.final_one = sorted_number.size() == 0;
         r.was_empty = 1'b0;
         if (r.final_one) arrivals = '0;
      end
      expected_takes.insert(expected_takes.size(), r);
   endfunction

   // Driver: a new request is presented only after the previous transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.command <= pending_requests[0].command;
            req_bus.first_key <= pending_requests[0].first_key;
            req_bus.second_key <= pending_requests[0].second_key;
            void'(pending_requests.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= $urandom_range(99) >= recv_idle_pct;
   end

   // Monitor: predicts on request transfers and checks response transfers.
   always @(posedge clock) begin
      take_result_type want;
      tkrs_pkg::req_entry_type e;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            e.command = req_bus.command;
            e.first_key = req_bus.first_key;
            e.second_key = req_bus.second_key;
            predict_request(e);
            accepted_count++;
            if (accepted_count < total_requests / 3) begin
               send_idle_pct = 28;
               recv_idle_pct = 51;
            end else if (accepted_count < 2 * total_requests / 3) begin
               send_idle_pct = 51;
               recv_idle_pct = 28;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_takes.size() == 0) begin
               report_mismatch("response transfer with no take pending");
            end else begin
               want = expected_takes.pop_front();
               if (rsp_bus.record_number !== want.record_number)
                  report_mismatch($sformatf("record_number %0d, expected %0d",
                                            rsp_bus.record_number, want.record_number));
               if (rsp_bus.final_one !== want.final_one)
                  report_mismatch($sformatf("final_one %b, expected %b",
                                            rsp_bus.final_one, want.final_one));
               if (rsp_bus.was_empty !== want.was_empty)
                  report_mismatch($sformatf("was_empty %b, expected %b",
                                            rsp_bus.was_empty, want.was_empty));
               if (rsp_bus.overflowed !== want.overflowed)
                  report_mismatch($sformatf("overflowed %b, expected %b",
                                            rsp_bus.overflowed, want.overflowed));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int fill;
      error_count = 0;
      accepted_count = 0;
      send_idle_pct = 28;
      recv_idle_pct = 51;
      arrivals = '0;
      overflow_seen = 1'b0;
      reset = 1'b1;

      // Directed: take on empty, key extremes, ties on both keys, drain and restart.
      queue_request(tkrs_pkg::CMD_TAKE, '0, '0);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff);
      queue_request(tkrs_pkg::CMD_INSERT, 32'hffff_ffff, 32'h0000_0000);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h0000_0000, 32'hffff_ffff);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h5555_5555, 32'haaaa_aaaa);
      queue_request(tkrs_pkg::CMD_INSERT, 32'haaaa_aaaa, 32'h5555_5555);
      for (int i = 0; i < 9; i++) queue_request(tkrs_pkg::CMD_TAKE, $urandom, $urandom);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h1, 32'h1);
      queue_request(tkrs_pkg::CMD_INSERT, 32'h1, 32'h1);
      queue_request(tkrs_pkg::CMD_TAKE, '1, '1);
      queue_request(tkrs_pkg::CMD_TAKE, '0, '0);

      // Fill past capacity, then keep the store full with take/insert pairs until
      // the arrival number saturates, then drain.
      for (int i = 0; i < tkrs_pkg::CAPACITY + 3; i++)
         queue_request(tkrs_pkg::CMD_INSERT, $urandom_range(3), $urandom_range(3));
      for (int i = 0; i < 265; i++) begin
         queue_request(tkrs_pkg::CMD_TAKE, $urandom, $urandom);
         queue_request(tkrs_pkg::CMD_INSERT, $urandom_range(3), $urandom_range(3));
      end
      for (int i = 0; i < tkrs_pkg::CAPACITY + 1; i++)
         queue_request(tkrs_pkg::CMD_TAKE, $urandom, $urandom);

      // Random: mostly fill-and-drain batches, with some mixed noise.
      while (pending_requests.size() < 1310) begin
         if ($urandom_range(3) != 0) begin
            fill = $urandom_range(12, 1);
            for (int i = 0; i < fill; i++)
               queue_request(tkrs_pkg::CMD_INSERT, pick_key(), pick_key());
            fill = fill + $urandom_range(1) - ($urandom_range(3) == 0);
            for (int i = 0; i < fill; i++)
               queue_request(tkrs_pkg::CMD_TAKE, $urandom, $urandom);
         end else begin
            for (int i = 0; i < 16; i++)
               queue_request(1'($urandom_range(1)), pick_key(), pick_key());
         end
      end
      // Leave the store empty so the last take costs little.
      for (int i = 0; i < 40; i++) queue_request(tkrs_pkg::CMD_TAKE, $urandom, $urandom);
      total_requests = pending_requests.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_requests) @(posedge clock);
      while (expected_takes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ----- files.f -----
sv/tkrs_pkg.sv
sv/tkrs_if.sv
sv/tkrs_front.sv
sv/tkrs_back.sv
sv/two_key_record_sorter.sv
verif/tb.sv
